// ----- hw/rtl/drsm_pkg.sv -----
// Shared definitions for the decision rule set matcher.
// Sizes, opcodes, controller states and the control/status bundles.
// No dependencies.
package drsm_pkg;

  // Table and sample sizes
  localparam int MAX_RULES      = 64;
  localparam int SLOTS_PER_RULE = 8;
  localparam int MAX_ATTRIBUTES = 256;
  localparam int VALUE_WIDTH    = 32;

  // Address widths derived from the sizes
  localparam int RULE_AW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int ATTR_AW = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;

  // Fixed port field widths
  localparam int OPCODE_W   = 2;
  localparam int RULE_NUM_W = 6;
  localparam int SLOT_NUM_W = 3;
  localparam int ATTR_IDX_W = 8;
  localparam int OPERAND_W  = 32;
  localparam int CFG_W      = 7;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_SLOT   = 2'd0,
    OP_WRITE_SAMPLE = 2'd1,
    OP_EVALUATE     = 2'd2,
    OP_CLEAR        = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DRAIN,
    ST_EMIT,
    ST_NONE
  } ctl_state_t;

  // One antecedent slot as stored in a lane RAM
  typedef struct packed {
    logic [ATTR_AW-1:0]     attr;
    logic                   dir;
    logic [VALUE_WIDTH-1:0] thr;
    logic                   valid;
  } slot_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic wr_slot;
    logic wr_sample;
    logic clr_table;
    logic eval_start;
    logic issue;
    logic emit_step;
    logic load_none;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic issue_last;
    logic pipe_busy;
    logic fire_zero;
    logic fire_rest_zero;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hw/rtl/decision_rule_set_matcher_core.sv -----
// Decision rule set matcher top level: controller plus datapath.
// Slot writes, sample writes and clears: a new beat every cycle while the controller is idle.
// Evaluate: all MAX_RULES rules are issued (one rule per cycle, slots in parallel lanes),
// the compare pipeline drains, then the activation bits are scanned up to the last active
// rule, holding while the result beat is not taken; with no active rule, one none beat.
// Synchronous active-low reset clears the rule table and rules_in_use.
module decision_rule_set_matcher_core import drsm_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [CFG_W-1:0]            cfg_wr_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [OPCODE_W-1:0]         in_opcode,
  input  logic [RULE_NUM_W-1:0]       in_rule_number,
  input  logic [SLOT_NUM_W-1:0]       in_slot_number,
  input  logic [ATTR_IDX_W-1:0]       in_attribute_index,
  input  logic                        in_greater_equal,
  input  logic                        in_slot_enable,
  input  logic signed [OPERAND_W-1:0] in_operand_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [RULE_NUM_W-1:0]       out_activated_rule,
  output logic                        out_last_of_run,
  output logic                        out_none_activated
);

  ctl_cmd_t   cmd;
  dp_status_t status;

  // Sequencer
  drsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_opcode (in_opcode),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and compare pipeline
  drsm_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_rule_number     (in_rule_number),
    .in_slot_number     (in_slot_number),
    .in_attribute_index (in_attribute_index),
    .in_greater_equal   (in_greater_equal),
    .in_slot_enable     (in_slot_enable),
    .in_operand_value   (in_operand_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_activated_rule (out_activated_rule),
    .out_last_of_run    (out_last_of_run),
    .out_none_activated (out_none_activated)
  );

endmodule

// ----- hw/rtl/drsm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module drsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/drsm_ctrl.sv -----
// Controller state machine of the decision rule set matcher.
// Depends on drsm_pkg; drives the datapath through ctl_cmd_t.
module drsm_ctrl import drsm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  dp_status_t          status,
  output ctl_cmd_t            cmd
);

  ctl_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode_t'(in_opcode))
            OP_WRITE_SLOT:   cmd.wr_slot   = 1'b1;
            OP_WRITE_SAMPLE: cmd.wr_sample = 1'b1;
            OP_CLEAR:        cmd.clr_table = 1'b1;
            OP_EVALUATE: begin
              cmd.eval_start = 1'b1;
              state_nxt      = ST_EVAL;
            end
            default: ;
          endcase
        end
      end
      // one rule issued per cycle
      ST_EVAL: begin
        cmd.issue = 1'b1;
        if (status.issue_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // let the last rules leave the compare pipeline
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_nxt = status.fire_zero ? ST_NONE : ST_EMIT;
        end
      end
      // scan activation bits, one rule per step
      ST_EMIT: begin
        cmd.emit_step = status.out_free;
        if (status.out_free && status.fire_rest_zero) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_NONE: begin
        cmd.load_none = status.out_free;
        if (status.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/drsm_datapath.sv -----
// Datapath of the decision rule set matcher: slot lane RAMs, sample RAM
// copies, compare pipeline, activation shift register and result register.
// Depends on drsm_pkg and drsm_ram.
module drsm_datapath import drsm_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ctl_cmd_t                     cmd,
  output dp_status_t                   status,
  input  logic                         cfg_wr_en,
  input  logic [CFG_W-1:0]             cfg_wr_data,
  input  logic [RULE_NUM_W-1:0]        in_rule_number,
  input  logic [SLOT_NUM_W-1:0]        in_slot_number,
  input  logic [ATTR_IDX_W-1:0]        in_attribute_index,
  input  logic                         in_greater_equal,
  input  logic                         in_slot_enable,
  input  logic signed [OPERAND_W-1:0]  in_operand_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [RULE_NUM_W-1:0]        out_activated_rule,
  output logic                         out_last_of_run,
  output logic                         out_none_activated
);

  // Configuration and control registers
  logic [CFG_W-1:0]     rules_in_use_r;
  logic [MAX_RULES-1:0] row_live_r, row_live_nxt;
  logic                 s1_v_r, s2_v_r;
  logic                 out_valid_r;

  // Pipeline and payload registers
  logic [RULE_AW-1:0]     rc_r;
  logic                   s1_use_r, s1_live_r;
  logic                   s2_use_r;
  logic                   s2_en_r  [SLOTS_PER_RULE];
  logic                   s2_dir_r [SLOTS_PER_RULE];
  logic [VALUE_WIDTH-1:0] s2_thr_r [SLOTS_PER_RULE];
  logic [MAX_RULES-1:0]   fire_r, fire_nxt;
  logic [RULE_AW-1:0]     emit_cnt_r;
  logic [RULE_NUM_W-1:0]  out_rule_r;
  logic                   out_last_r, out_none_r;

  // Lane RAM ports
  slot_entry_t            lane_wdata [SLOTS_PER_RULE];
  logic                   lane_we    [SLOTS_PER_RULE];
  slot_entry_t            lane_rdata [SLOTS_PER_RULE];
  logic [VALUE_WIDTH-1:0] smp_rdata  [SLOTS_PER_RULE];
  logic                   lane_ok    [SLOTS_PER_RULE];

  logic                   slot_ok, smp_we, wr_live, s2_fire, all_ok, out_free;
  logic [RULE_AW-1:0]     wr_row;
  logic [ATTR_AW-1:0]     wr_attr;
  logic [VALUE_WIDTH-1:0] wr_value;

  // Write decode: out-of-range writes are dropped
  assign slot_ok  = (32'(in_rule_number) < MAX_RULES) &&
                    (32'(in_slot_number) < SLOTS_PER_RULE) &&
                    (32'(in_attribute_index) < MAX_ATTRIBUTES);
  assign smp_we   = cmd.wr_sample && (32'(in_attribute_index) < MAX_ATTRIBUTES);
  assign wr_row   = RULE_AW'(in_rule_number);
  assign wr_attr  = ATTR_AW'(in_attribute_index);
  assign wr_value = VALUE_WIDTH'(in_operand_value);
  assign wr_live  = row_live_r[wr_row];

  // Row live bits: a cleared row reads as all slots free
  always_comb begin
    row_live_nxt = row_live_r;
    if (cmd.clr_table) begin
      row_live_nxt = '0;
    end else if (cmd.wr_slot && slot_ok) begin
      row_live_nxt[wr_row] = 1'b1;
    end
  end

  // Lanes: one RAM per slot position plus its own sample copy
  for (genvar s = 0; s < SLOTS_PER_RULE; s++) begin : g_lane
    logic sel;
    assign sel = (32'(in_slot_number) == s);
    // a write into a dead row frees the row's other slots
    assign lane_we[s]    = cmd.wr_slot && slot_ok && (sel || !wr_live);
    assign lane_wdata[s] = '{attr: wr_attr, dir: in_greater_equal, thr: wr_value,
                             valid: sel && in_slot_enable};

    drsm_ram #(.WIDTH($bits(slot_entry_t)), .DEPTH(MAX_RULES)) u_slot_ram (
      .clk   (clk),
      .we    (lane_we[s]),
      .waddr (wr_row),
      .wdata (lane_wdata[s]),
      .raddr (rc_r),
      .rdata (lane_rdata[s])
    );

    drsm_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(MAX_ATTRIBUTES)) u_sample_ram (
      .clk   (clk),
      .we    (smp_we),
      .waddr (wr_attr),
      .wdata (wr_value),
      .raddr (lane_rdata[s].attr),
      .rdata (smp_rdata[s])
    );

    // slot holds when free, or when the compare goes the required way
    assign lane_ok[s] = !s2_en_r[s] ||
      (s2_dir_r[s] == ($signed(smp_rdata[s]) >= $signed(s2_thr_r[s])));
  end

  // AND of all lanes
  always_comb begin
    all_ok = 1'b1;
    for (int s = 0; s < SLOTS_PER_RULE; s++) begin
      all_ok = all_ok & lane_ok[s];
    end
  end
  assign s2_fire = s2_use_r && all_ok;

  // Activation shift register: filled at the top, drained from bit 0
  always_comb begin
    fire_nxt = fire_r;
    if (s2_v_r) begin
      fire_nxt = fire_r >> 1;
      fire_nxt[MAX_RULES-1] = s2_fire;
    end else if (cmd.emit_step) begin
      fire_nxt = fire_r >> 1;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rules_in_use_r <= '0;
      row_live_r     <= '0;
      s1_v_r         <= 1'b0;
      s2_v_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rules_in_use_r <= cfg_wr_data;
      end
      row_live_r <= row_live_nxt;
      s1_v_r     <= cmd.issue;
      s2_v_r     <= s1_v_r;
      if (cmd.load_none || (cmd.emit_step && fire_r[0])) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Issue counter, pipeline stages, emit counter and result payload
  always_ff @(posedge clk) begin
    if (cmd.eval_start) begin
      rc_r <= '0;
    end else if (cmd.issue) begin
      rc_r <= rc_r + 1'b1;
    end
    s1_use_r  <= 32'(rc_r) < 32'(rules_in_use_r);
    s1_live_r <= row_live_r[rc_r];
    s2_use_r  <= s1_use_r;
    for (int s = 0; s < SLOTS_PER_RULE; s++) begin
      s2_en_r[s]  <= s1_live_r && lane_rdata[s].valid;
      s2_dir_r[s] <= lane_rdata[s].dir;
      s2_thr_r[s] <= lane_rdata[s].thr;
    end
    fire_r <= fire_nxt;
    if (cmd.eval_start) begin
      emit_cnt_r <= '0;
    end else if (cmd.emit_step) begin
      emit_cnt_r <= emit_cnt_r + 1'b1;
    end
    if (cmd.load_none) begin
      out_rule_r <= '0;
      out_last_r <= 1'b1;
      out_none_r <= 1'b1;
    end else if (cmd.emit_step && fire_r[0]) begin
      out_rule_r <= RULE_NUM_W'(emit_cnt_r);
      out_last_r <= status.fire_rest_zero;
      out_none_r <= 1'b0;
    end
  end

  // Status to controller
  assign status = '{issue_last:     (32'(rc_r) == (MAX_RULES - 1)),
                    pipe_busy:      (s1_v_r || s2_v_r),
                    fire_zero:      (fire_r == '0),
                    fire_rest_zero: ((fire_r >> 1) == '0),
                    out_free:       out_free};

  assign out_valid          = out_valid_r;
  assign out_activated_rule = out_rule_r;
  assign out_last_of_run    = out_last_r;
  assign out_none_activated = out_none_r;

endmodule

// ----- tb/sv/tb_decision_rule_set_matcher_core.sv -----
// Testbench for decision_rule_set_matcher_core: drives rule table, sample and
// evaluate beats and checks every result beat against an in-bench rule model.
// Depends on drsm_pkg and the matcher core RTL.
module tb_decision_rule_set_matcher_core;
  timeunit 1ns;
  timeprecision 1ps;
  import drsm_pkg::*;

  localparam int SLOT_TOTAL   = MAX_RULES * SLOTS_PER_RULE;
  localparam int MAX_GAP      = 12;
  localparam int DRAIN_PAD    = 200;   // covers a full evaluate and its emit scan
  localparam int LONG_HOLD    = 500;
  localparam int STALL_LIMIT  = 5000;
  localparam int SHOWN_ERRORS = 10;

  // One expected result beat
  typedef struct packed {
    logic [RULE_NUM_W-1:0] rule;
    logic                  is_last;
    logic                  is_none;
  } hit_beat_t;

  // One command beat on the input channel
  typedef struct {
    opcode_t                     op;
    logic [RULE_NUM_W-1:0]       rule;
    logic [SLOT_NUM_W-1:0]       slot;
    logic [ATTR_IDX_W-1:0]       attr;
    logic                        ge;
    logic                        en;
    logic signed [OPERAND_W-1:0] value;
  } rule_cmd_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [CFG_W-1:0]            cfg_wr_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [OPCODE_W-1:0]         in_opcode;
  logic [RULE_NUM_W-1:0]       in_rule_number;
  logic [SLOT_NUM_W-1:0]       in_slot_number;
  logic [ATTR_IDX_W-1:0]       in_attribute_index;
  logic                        in_greater_equal;
  logic                        in_slot_enable;
  logic signed [OPERAND_W-1:0] in_operand_value;
  logic                        out_valid;
  logic                        out_ready;
  logic [RULE_NUM_W-1:0]       out_activated_rule;
  logic                        out_last_of_run;
  logic                        out_none_activated;

  // Rule table and sample mirror
  logic [ATTR_IDX_W-1:0]       tbl_attr [SLOT_TOTAL];
  logic                        tbl_ge   [SLOT_TOTAL];
  logic signed [OPERAND_W-1:0] tbl_thr  [SLOT_TOTAL];
  logic                        tbl_used [SLOT_TOTAL];
  logic signed [OPERAND_W-1:0] sample_mem  [MAX_ATTRIBUTES];
  logic                        sample_seen [MAX_ATTRIBUTES];
  int unsigned                 known_attrs [$];
  int                          rules_cfg;
  hit_beat_t                   pending_hits [$];

  // Run control and bookkeeping
  bit tx_gaps_on;
  bit rx_gaps_on;
  int rx_hold;
  int mismatches;
  int beats_in;
  int beats_out;
  int evals;
  int none_runs;
  int cfg_writes;
  int long_holds;
  int in_stall_cycles;
  int idle_cycles;

  decision_rule_set_matcher_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_rule_number     (in_rule_number),
    .in_slot_number     (in_slot_number),
    .in_attribute_index (in_attribute_index),
    .in_greater_equal   (in_greater_equal),
    .in_slot_enable     (in_slot_enable),
    .in_operand_value   (in_operand_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_activated_rule (out_activated_rule),
    .out_last_of_run    (out_last_of_run),
    .out_none_activated (out_none_activated)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Rule model
  // ---------------------------------------------------------------------------

  function automatic void clear_rule_model();
    for (int k = 0; k < SLOT_TOTAL; k++) begin
      tbl_attr[k] = '0;
      tbl_ge[k]   = 1'b0;
      tbl_thr[k]  = '0;
      tbl_used[k] = 1'b0;
    end
    for (int a = 0; a < MAX_ATTRIBUTES; a++) begin
      sample_mem[a]  = '0;
      sample_seen[a] = 1'b0;
    end
    known_attrs.delete();
    rules_cfg = 0;
  endfunction

  // All enabled slots of a rule must hold; an empty rule always holds
  function automatic bit rule_holds(int r);
    int   k;
    logic ge_ok;
    for (int s = 0; s < SLOTS_PER_RULE; s++) begin
      k = r * SLOTS_PER_RULE + s;
      if (tbl_used[k]) begin
        ge_ok = (sample_mem[tbl_attr[k]] >= tbl_thr[k]);
        if (tbl_ge[k] ? !ge_ok : ge_ok) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  // Update the mirror for one accepted beat and queue the result beats it causes
  function automatic void apply_rule_cmd(rule_cmd_t c);
    int               k;
    int               n;
    int               top;
    logic [63:0]      fired;
    hit_beat_t        b;
    case (c.op)
      OP_WRITE_SLOT: begin
        k = int'(c.rule) * SLOTS_PER_RULE + int'(c.slot);
        tbl_attr[k] = c.attr;
        tbl_ge[k]   = c.ge;
        tbl_thr[k]  = c.value;
        tbl_used[k] = c.en;
      end
      OP_WRITE_SAMPLE: begin
        sample_mem[c.attr] = c.value;
        if (!sample_seen[c.attr]) begin
          sample_seen[c.attr] = 1'b1;
          known_attrs.insert(known_attrs.size(), 32'(c.attr));
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOT_TOTAL; i++) tbl_used[i] = 1'b0;
      end
      default: begin
        // evaluate: ascending activated rules, or one none beat
        n     = (rules_cfg > MAX_RULES) ? MAX_RULES : rules_cfg;
        fired = '0;
        top   = -1;
        evals++;
        for (int r = 0; r < n; r++) begin
          if (rule_holds(r)) begin
            fired[r] = 1'b1;
            top      = r;
          end
        end
        if (top < 0) begin
          b.rule    = '0;
          b.is_last = 1'b1;
          b.is_none = 1'b1;
          pending_hits.insert(pending_hits.size(), b);
          none_runs++;
        end else begin
          for (int r = 0; r <= top; r++) begin
            if (fired[r]) begin
              b.rule    = r[RULE_NUM_W-1:0];
              b.is_last = (r == top);
              b.is_none = 1'b0;
              pending_hits.insert(pending_hits.size(), b);
            end
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  // Unused fields carry random noise
  function automatic rule_cmd_t noise_cmd(opcode_t op);
    rule_cmd_t c;
    c.op    = op;
    c.rule  = RULE_NUM_W'($urandom);
    c.slot  = SLOT_NUM_W'($urandom);
    c.attr  = ATTR_IDX_W'($urandom);
    c.ge    = 1'($urandom);
    c.en    = 1'($urandom);
    c.value = $urandom;
    return c;
  endfunction

  function automatic rule_cmd_t slot_cmd(int r, int s, int a, bit ge, bit en,
                                         logic signed [OPERAND_W-1:0] v);
    rule_cmd_t c;
    c       = noise_cmd(OP_WRITE_SLOT);
    c.rule  = RULE_NUM_W'(r);
    c.slot  = SLOT_NUM_W'(s);
    c.attr  = ATTR_IDX_W'(a);
    c.ge    = ge;
    c.en    = en;
    c.value = v;
    return c;
  endfunction

  function automatic rule_cmd_t sample_cmd(int a, logic signed [OPERAND_W-1:0] v);
    rule_cmd_t c;
    c       = noise_cmd(OP_WRITE_SAMPLE);
    c.attr  = ATTR_IDX_W'(a);
    c.value = v;
    return c;
  endfunction

  // Q16.16 values biased toward extremes and small numbers
  function automatic logic signed [OPERAND_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      4:       return (int'($urandom_range(0, 15)) - 8) <<< 16;
      default: return $urandom;
    endcase
  endfunction

  // More slot writes than any other beat, mostly against the active rules, thresholds near the samples
  function automatic rule_cmd_t random_cmd();
    rule_cmd_t c;
    int        pick;
    int        span;
    int        delta;
    pick = $urandom_range(0, 99);
    if (known_attrs.size() == 0 || pick < 20) begin
      c      = noise_cmd(OP_WRITE_SAMPLE);
      c.attr = ($urandom_range(0, 2) == 0) ? ATTR_IDX_W'($urandom_range(0, MAX_ATTRIBUTES - 1))
                                           : ATTR_IDX_W'($urandom_range(0, 15));
      c.value = pick_value();
    end else if (pick < 65) begin
      c      = noise_cmd(OP_WRITE_SLOT);
      span   = (rules_cfg < 1) ? 1 : ((rules_cfg > MAX_RULES) ? MAX_RULES : rules_cfg);
      c.rule = ($urandom_range(0, 99) < 85) ? RULE_NUM_W'($urandom_range(0, span - 1))
                                            : RULE_NUM_W'($urandom_range(0, MAX_RULES - 1));
      c.slot = SLOT_NUM_W'($urandom_range(0, SLOTS_PER_RULE - 1));
      c.en   = ($urandom_range(0, 9) < 8);
      // an enabled slot only points at a sample that has been written
      c.attr = c.en ? ATTR_IDX_W'(known_attrs[$urandom_range(0, known_attrs.size() - 1)])
                    : ATTR_IDX_W'($urandom_range(0, MAX_ATTRIBUTES - 1));
      if ($urandom_range(0, 1) == 1) begin
        delta   = int'($urandom_range(0, 2)) - 1;
        c.value = sample_mem[c.attr] + delta;
      end else begin
        c.value = pick_value();
      end
    end else if (pick < 97) begin
      c = noise_cmd(OP_EVALUATE);
    end else begin
      c = noise_cmd(OP_CLEAR);
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one beat after a random gap when gaps are on; returns at the accepting edge
  task automatic send_beat(rule_cmd_t c);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_opcode          <= c.op;
    in_rule_number     <= c.rule;
    in_slot_number     <= c.slot;
    in_attribute_index <= c.attr;
    in_greater_equal   <= c.ge;
    in_slot_enable     <= c.en;
    in_operand_value   <= c.value;
    do @(posedge clk); while (!in_ready);
    apply_rule_cmd(c);
    beats_in++;
  endtask

  // Stop offering and wait until every expected beat has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_hits.size() != 0);
  endtask

  // Register write while the block is idle
  task automatic set_rule_count(int v);
    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CFG_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rules_cfg = v;
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Receiver: random stalls per beat, plus an occasional long hold-off
  initial begin
    int w;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        w       = rx_hold;
        rx_hold = 0;
        long_holds++;
      end else begin
        w = rx_gaps_on ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic void flag_error(string msg);
    mismatches++;
    if (mismatches <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  // Compare each accepted result beat with the oldest expectation
  always @(posedge clk) begin : check_results
    hit_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (pending_hits.size() == 0) begin
        flag_error($sformatf("unexpected beat rule=%0d last=%0b none=%0b",
                             out_activated_rule, out_last_of_run, out_none_activated));
      end else begin
        want = pending_hits.pop_front();
        if (out_activated_rule !== want.rule || out_last_of_run !== want.is_last ||
            out_none_activated !== want.is_none)
          flag_error($sformatf({"rule exp %0d act %0d, last exp %0b act %0b, ",
                                "none exp %0b act %0b"},
                               want.rule, out_activated_rule, want.is_last,
                               out_last_of_run, want.is_none, out_none_activated));
      end
    end
  end

  // Watchdog on cycles without any accepted beat; also counts input stalls
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_ready) in_stall_cycles++;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Zero rules in use gives the none beat
  task automatic test_empty_table();
    set_rule_count(0);
    send_beat(noise_cmd(OP_EVALUATE));
    send_beat(noise_cmd(OP_CLEAR));
  endtask

  // Threshold equality, value extremes, both directions, freeing a slot
  task automatic test_compare_edges();
    send_beat(sample_cmd(0, 32'sh8000_0000));
    send_beat(sample_cmd(MAX_ATTRIBUTES - 1, 32'sh7FFF_FFFF));
    send_beat(sample_cmd(1, 32'sh0000_0000));
    send_beat(sample_cmd(2, 32'sh0001_0000));
    set_rule_count(4);
    send_beat(noise_cmd(OP_EVALUATE));                               // empty rules fire
    send_beat(slot_cmd(0, 0, 0, 1'b1, 1'b1, 32'sh8000_0000));        // min >= min
    send_beat(slot_cmd(1, SLOTS_PER_RULE - 1, 0, 1'b0, 1'b1, 32'sh8000_0000)); // min < min
    send_beat(slot_cmd(2, 3, MAX_ATTRIBUTES - 1, 1'b1, 1'b1, 32'sh7FFF_FFFF)); // max >= max
    send_beat(slot_cmd(2, 4, 2, 1'b0, 1'b1, 32'sh0001_0001));        // 1.0 < 1.0+lsb
    send_beat(slot_cmd(3, 0, 1, 1'b1, 1'b1, 32'sh0000_0001));        // 0 >= lsb fails
    send_beat(noise_cmd(OP_EVALUATE));
    send_beat(slot_cmd(3, 0, 1, 1'b1, 1'b0, 32'sh0000_0001));        // freed slot
    send_beat(slot_cmd(MAX_RULES - 1, SLOTS_PER_RULE - 1, MAX_ATTRIBUTES - 1,
                       1'b0, 1'b1, 32'sh7FFF_FFFF));                 // max < max fails
    send_beat(noise_cmd(OP_EVALUATE));
  endtask

  // Saturating rule count, table clear, none beat with rules in use
  task automatic test_clear_and_saturate();
    set_rule_count(127);
    send_beat(noise_cmd(OP_EVALUATE));
    send_beat(noise_cmd(OP_CLEAR));
    send_beat(noise_cmd(OP_EVALUATE));
    set_rule_count(1);
    send_beat(slot_cmd(0, 1, MAX_ATTRIBUTES - 1, 1'b0, 1'b1, 32'sh0000_0000));
    send_beat(noise_cmd(OP_EVALUATE));
    set_rule_count(MAX_RULES);
    send_beat(noise_cmd(OP_EVALUATE));
  endtask

  // Long receiver hold-off while evaluates keep coming: input must back up
  task automatic test_output_backlog();
    tx_gaps_on = 1'b0;
    rx_hold    = LONG_HOLD;
    repeat (6) send_beat(noise_cmd(OP_EVALUATE));
    wait_drained();
    tx_gaps_on = 1'b1;
  endtask

  // Random phases over several rule counts, idle patterns and drain pauses
  task automatic test_random_traffic(int total);
    int counts [7];
    int per_phase;
    counts    = '{MAX_RULES, 3, 127, 0, MAX_RULES, 1, 0};
    counts[3] = $urandom_range(0, 127);
    counts[6] = $urandom_range(0, 127);
    per_phase = total / 7;
    foreach (counts[p]) begin
      set_rule_count(counts[p]);
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < per_phase; i++) begin
        send_beat(random_cmd());
        if ($urandom_range(0, 39) == 0) wait_drained();
      end
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              <= 1'b0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    in_valid           <= 1'b0;
    in_opcode          <= OP_WRITE_SLOT;
    in_rule_number     <= '0;
    in_slot_number     <= '0;
    in_attribute_index <= '0;
    in_greater_equal   <= 1'b0;
    in_slot_enable     <= 1'b0;
    in_operand_value   <= '0;
    tx_gaps_on      = 1'b1;
    rx_gaps_on      = 1'b1;
    rx_hold         = 0;
    mismatches      = 0;
    beats_in        = 0;
    beats_out       = 0;
    evals           = 0;
    none_runs       = 0;
    cfg_writes      = 0;
    long_holds      = 0;
    in_stall_cycles = 0;
    idle_cycles     = 0;
    clear_rule_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_compare_edges();
    test_clear_and_saturate();
    test_output_backlog();
    test_random_traffic(350);

    wait_drained();
    repeat (DRAIN_PAD) @(posedge clk);
    if (pending_hits.size() != 0)
      flag_error($sformatf("%0d expected beats never arrived", pending_hits.size()));

    $display("Covered %0d command beats, %0d evaluations (%0d with no rule active),",
             beats_in, evals, none_runs);
    $display("%0d result beats; rule count written %0d times incl. 0, 1, 64 and 127;",
             beats_out, cfg_writes);
    $display("%0d long hold-offs, %0d input stall cycles", long_holds, in_stall_cycles);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/drsm_pkg.sv
hw/rtl/drsm_ram.sv
hw/rtl/drsm_ctrl.sv
hw/rtl/drsm_datapath.sv
hw/rtl/decision_rule_set_matcher_core.sv
tb/sv/tb_decision_rule_set_matcher_core.sv
